[src/sterm_pkg.sv]
// Shared types and constants for the sorted term table.
package sterm_pkg;

   // operation codes carried in req_tuser
   localparam logic [2:0] KIND_INSERT = 3'd0;
   localparam logic [2:0] KIND_REMOVE = 3'd1;
   localparam logic [2:0] KIND_READ   = 3'd2;
   localparam logic [2:0] KIND_LOOKUP = 3'd3;
   localparam logic [2:0] KIND_CLEAR  = 3'd4;

   localparam int KIND_W  = 3;
   localparam int KEY_W   = 16;
   localparam int VAL_W   = 32;
   localparam int POS_W   = 4;
   localparam int CNT_W   = 5;
   // cells reachable through the position field
   localparam int POS_CELLS = 1 << POS_W;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 56;

   // controller to datapath commands
   typedef struct packed {
      logic load;   // capture request and per-cell compare results
      logic exec;   // apply operation to the cells, load response register
   } cmd_type;

endpackage

[src/sterm_ctrl.sv]
// Controller state machine: sequences capture, execute and response transfer.
module sterm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output sterm_pkg::cmd_type cmd
);
   import sterm_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.load     = 1'b0;
      cmd.exec     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold until the response register can take the result
            if (slot_free) begin
               cmd.exec     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[src/sterm_dp.sv]
// Datapath: row of key/value cells with broadcast compare, shift logic and response register.
module sterm_dp #(
   parameter int CAPACITY = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sterm_pkg::cmd_type                cmd,
   input  logic [sterm_pkg::KIND_W-1:0]      kind,
   input  logic signed [sterm_pkg::KEY_W-1:0] exponent_in,
   input  logic signed [sterm_pkg::VAL_W-1:0] coefficient_in,
   input  logic [sterm_pkg::POS_W-1:0]       position,
   output logic                              ok,
   output logic signed [sterm_pkg::KEY_W-1:0] exponent_out,
   output logic signed [sterm_pkg::VAL_W-1:0] coefficient_out,
   output logic [sterm_pkg::CNT_W-1:0]       entry_count
);
   import sterm_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = (CW > CNT_W) ? CW : CNT_W;
   localparam int MW = (CW > POS_W) ? CW : POS_W;
   localparam int RC = (CAPACITY < POS_CELLS) ? CAPACITY : POS_CELLS;

   // cells
   logic signed [KEY_W-1:0] cell_key_ff [CAPACITY];
   logic signed [KEY_W-1:0] cell_key_in [CAPACITY];
   logic signed [VAL_W-1:0] cell_val_ff [CAPACITY];
   logic signed [VAL_W-1:0] cell_val_in [CAPACITY];
   logic [CW-1:0]           count_ff, count_in;

   // captured request and per-cell compare flags
   logic [KIND_W-1:0]       kind_ff;
   logic signed [KEY_W-1:0] key_ff;
   logic signed [VAL_W-1:0] val_ff;
   logic [POS_W-1:0]        pos_ff;
   logic [CAPACITY-1:0]     lt_ff, lt_in;
   logic [CAPACITY-1:0]     eq_ff, eq_in;

   // response register
   logic                    ok_ff, ok_in;
   logic signed [KEY_W-1:0] exp_ff, exp_in;
   logic signed [VAL_W-1:0] coef_ff, coef_in;

   logic [CAPACITY-1:0]     valid_cell;
   logic [CAPACITY-1:0]     lt_prev;
   logic [CAPACITY-1:0]     hit;
   logic                    found;
   logic signed [VAL_W-1:0] hit_val;
   logic signed [KEY_W-1:0] rd_key;
   logic signed [VAL_W-1:0] rd_val;
   logic                    rd_ok;
   logic [EW-1:0]           count_ext;

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         valid_cell[i] = CW'(i) < count_ff;
         lt_in[i]      = valid_cell[i] && (cell_key_ff[i] < exponent_in);
         eq_in[i]      = (cell_key_ff[i] == exponent_in);
      end
   end

   // thermometer of "below key" flags: the first clear one marks the slot
   assign lt_prev = {lt_ff[CAPACITY-2:0], 1'b1};
   assign hit     = valid_cell & ~lt_ff & lt_prev & eq_ff;

   always_comb begin
      found   = 1'b0;
      hit_val = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         found   = found | hit[i];
         hit_val = hit_val | (hit[i] ? cell_val_ff[i] : '0);
      end
   end

   always_comb begin
      rd_key = '0;
      rd_val = '0;
      for (int i = 0; i < RC; i++) begin
         if (pos_ff == POS_W'(i)) begin
            rd_key = cell_key_ff[i];
            rd_val = cell_val_ff[i];
         end
      end
      rd_ok = MW'(pos_ff) < MW'(count_ff);
   end

   always_comb begin
      cell_key_in = cell_key_ff;
      cell_val_in = cell_val_ff;
      count_in    = count_ff;
      ok_in       = 1'b0;
      exp_in      = '0;
      coef_in     = '0;
      unique case (kind_ff)
         KIND_INSERT: begin
            if (count_ff < CW'(CAPACITY)) begin
               for (int i = 0; i < CAPACITY; i++) begin
                  if (!lt_ff[i]) begin
                     if (lt_prev[i]) begin
                        cell_key_in[i] = key_ff;
                        cell_val_in[i] = val_ff;
                     end else begin
                        cell_key_in[i] = cell_key_ff[(i + CAPACITY - 1) % CAPACITY];
                        cell_val_in[i] = cell_val_ff[(i + CAPACITY - 1) % CAPACITY];
                     end
                  end
               end
               count_in = count_ff + CW'(1);
               ok_in    = 1'b1;
            end
         end
         KIND_REMOVE: begin
            if (found) begin
               for (int i = 0; i < CAPACITY - 1; i++) begin
                  if (!lt_ff[i]) begin
                     cell_key_in[i] = cell_key_ff[i + 1];
                     cell_val_in[i] = cell_val_ff[i + 1];
                  end
               end
               count_in = count_ff - CW'(1);
               ok_in    = 1'b1;
            end
         end
         KIND_READ: begin
            if (rd_ok) begin
               ok_in   = 1'b1;
               exp_in  = rd_key;
               coef_in = rd_val;
            end
         end
         KIND_LOOKUP: begin
            if (found) begin
               ok_in   = 1'b1;
               coef_in = hit_val;
            end
         end
         KIND_CLEAR: begin
            count_in = '0;
            ok_in    = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= kind;
         key_ff  <= exponent_in;
         val_ff  <= coefficient_in;
         pos_ff  <= position;
         lt_ff   <= lt_in;
         eq_ff   <= eq_in;
      end
      if (cmd.exec) begin
         cell_key_ff <= cell_key_in;
         cell_val_ff <= cell_val_in;
         ok_ff       <= ok_in;
         exp_ff      <= exp_in;
         coef_ff     <= coef_in;
      end
   end

   assign count_ext       = EW'(count_ff);
   assign ok              = ok_ff;
   assign exponent_out    = exp_ff;
   assign coefficient_out = coef_ff;
   // entry_count tracks the count after the operation that made this response
   assign entry_count     = count_ext[CNT_W-1:0];

endmodule

[src/sorted_term_table.sv]
// Sorted term table: up to CAPACITY (exponent, coefficient) entries kept in ascending
// exponent order, with insert, remove, read by position, lookup by exponent and clear.
// Each operation has a capture step, which takes the request while every cell compares
// its key with the broadcast exponent, and an execute step that shifts the cells and
// loads the response register. A new request waits until the last one has executed;
// a stalled response delays the next execute step. Reset empties the table at once.
module sorted_term_table #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] exponent_in, [47:16] coefficient_in, [51:48] position, [55:52] zero
   input  logic [55:0] req_tdata,
   // [2:0] kind
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] ok, [16:1] exponent_out, [48:17] coefficient_out, [53:49] entry_count,
   // [55:54] zero
   output logic [55:0] rsp_tdata
);
   import sterm_pkg::*;

   cmd_type                 cmd;
   logic                    ok;
   logic signed [KEY_W-1:0] exponent_out;
   logic signed [VAL_W-1:0] coefficient_out;
   logic [CNT_W-1:0]        entry_count;

   sterm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   sterm_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .kind            (req_tuser),
      .exponent_in     (req_tdata[15:0]),
      .coefficient_in  (req_tdata[47:16]),
      .position        (req_tdata[51:48]),
      .ok              (ok),
      .exponent_out    (exponent_out),
      .coefficient_out (coefficient_out),
      .entry_count     (entry_count)
   );

   assign rsp_tdata = {2'b00, entry_count, coefficient_out, exponent_out, ok};

endmodule
